// ===== sv/pdmo_pkg.sv =====
// pdmo_pkg: shared types, register indexes, opcodes and saturation helper
// for the phase to depth converter; no dependencies
package pdmo_pkg;

  // divider operand widths: numerator covers the plane product and bin numerator
  localparam int DIV_NW    = 46;
  localparam int DIV_DW    = 31;
  localparam int BIN_IDX_W = 12;
  localparam int CNT_W     = 20;
  localparam int SAT_W     = 65;

  localparam logic [2:0] REG_WIDTH    = 3'd0;
  localparam logic [2:0] REG_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_ORIENT   = 3'd2;
  localparam logic [2:0] REG_SCALE    = 3'd3;
  localparam logic [2:0] REG_SKEW     = 3'd4;
  localparam logic [2:0] REG_BIN_SIZE = 3'd5;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic signed [SAT_W-1:0] SAT_HI = 65'sd2147483647;
  localparam logic signed [SAT_W-1:0] SAT_LO = -65'sd2147483648;

  typedef enum logic [1:0] {
    HOP_NONE,
    HOP_INC,
    HOP_CLEAR,
    HOP_SCAN
  } hist_op_t;

  typedef struct packed {
    hist_op_t               op;
    logic [BIN_IDX_W-1:0]   bin;
  } hist_cmd_t;

  typedef struct packed {
    logic                   busy;
    logic [BIN_IDX_W-1:0]   best;
  } hist_stat_t;

  typedef enum logic [2:0] {
    H_SWEEP,
    H_IDLE,
    H_INC_WR,
    H_SCAN,
    H_SCAN_LAST
  } hist_state_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR_WAIT,
    S_PLANE,
    S_PLANE_WAIT,
    S_MUL,
    S_DEPTH,
    S_BIN,
    S_BIN_WAIT,
    S_HIST,
    S_STORE,
    S_SCAN_REQ,
    S_SCAN_WAIT,
    S_RD_OUT
  } pdmo_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    if (v > SAT_HI) begin
      return 32'sh7fffffff;
    end else if (v < SAT_LO) begin
      return 32'sh80000000;
    end else begin
      return $signed(v[31:0]);
    end
  endfunction

endpackage

// ===== sv/pdmo_div.sv =====
// pdmo_div: restoring unsigned divider, one quotient bit per cycle
// standalone, no package dependency
module pdmo_div #(
  parameter int NW = 46,
  parameter int DW = 31
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic          rem_nz
);

  localparam int CNTW = $clog2(NW + 1);

  logic [DW-1:0]   rem;
  logic [DW-1:0]   den_r;
  logic [CNTW-1:0] cnt;
  logic [DW:0]     r_sh;

  assign r_sh   = {rem, quo[NW-1]};
  assign rem_nz = |rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift/subtract datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      if (r_sh >= {1'b0, den_r}) begin
        rem <= DW'(r_sh - {1'b0, den_r});
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= r_sh[DW-1:0];
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== sv/pdmo_hist.sv =====
// pdmo_hist: depth histogram in a one-port-read synchronous memory with
// increment, clearing sweep and fullest-bin scan that zeroes each bin it reads; uses pdmo_pkg
module pdmo_hist #(
  parameter int BIN_COUNT = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pdmo_pkg::hist_cmd_t   cmd,
  output pdmo_pkg::hist_stat_t  stat
);
  import pdmo_pkg::*;

  localparam int BW = $clog2(BIN_COUNT);
  localparam logic [BW-1:0] LAST = BW'(BIN_COUNT - 1);

  logic [CNT_W-1:0] mem [BIN_COUNT];
  logic [CNT_W-1:0] rdata;

  hist_state_t      state, state_next;
  logic [BW-1:0]    ptr;
  logic [BW-1:0]    bin_r;
  logic             cmp_valid;
  logic [BW-1:0]    cmp_idx;
  logic [BW-1:0]    best;
  logic [CNT_W-1:0] best_cnt;

  logic             re, we;
  logic [BW-1:0]    raddr, waddr;
  logic [CNT_W-1:0] wdata;

  always_comb begin
    state_next = state;
    case (state)
      H_SWEEP:     if (ptr == LAST) state_next = H_IDLE;
      H_IDLE: begin
        case (cmd.op)
          HOP_INC:   state_next = H_INC_WR;
          HOP_CLEAR: state_next = H_SWEEP;
          HOP_SCAN:  state_next = H_SCAN;
          default:   state_next = H_IDLE;
        endcase
      end
      H_INC_WR:    state_next = H_IDLE;
      H_SCAN:      if (ptr == LAST) state_next = H_SCAN_LAST;
      H_SCAN_LAST: state_next = H_IDLE;
      default:     state_next = H_IDLE;
    endcase
  end

  always_comb begin
    re    = 1'b0;
    we    = 1'b0;
    raddr = ptr;
    waddr = ptr;
    wdata = '0;
    case (state)
      H_SWEEP: we = 1'b1;
      H_IDLE: begin
        if (cmd.op == HOP_INC) begin
          re    = 1'b1;
          raddr = cmd.bin[BW-1:0];
        end
      end
      H_INC_WR: begin
        we    = 1'b1;
        waddr = bin_r;
        wdata = (&rdata) ? rdata : rdata + 1'b1;
      end
      H_SCAN: begin
        // read each bin and zero it behind the read
        re = 1'b1;
        we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= H_SWEEP;
      ptr       <= '0;
      cmp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cmp_valid <= (state == H_SCAN);
      if (state == H_IDLE) begin
        ptr <= '0;
      end else if (state == H_SWEEP || state == H_SCAN) begin
        ptr <= ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= ptr;
    if (state == H_IDLE) begin
      bin_r <= cmd.bin[BW-1:0];
    end
    if (state == H_IDLE && cmd.op == HOP_SCAN) begin
      best     <= '0;
      best_cnt <= '0;
    end else if (cmp_valid && rdata > best_cnt) begin
      best     <= cmp_idx;
      best_cnt <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
    if (we) mem[waddr] <= wdata;
  end

  assign stat.busy = (state != H_IDLE);
  assign stat.best = BIN_IDX_W'(best);

endmodule

// ===== sv/phase_depth_mode_offset.sv =====
// phase_depth_mode_offset: top level, sequencer, depth store and output register
// depends on pdmo_pkg, pdmo_div and pdmo_hist
//
// Converts one frame of unwrapped Q16.16 phase pixels, loaded in raster order,
// into depth: an unmasked pixel gets (phase - plane) * depth_scale, the plane being
// (x/width - 1/2) * depth_skew for vertical fringes or (y/height) * depth_skew for
// horizontal ones; a masked pixel stores 0. Unmasked depths land in BIN_COUNT
// clamped histogram bins; after the last pixel the lowest fullest bin sets the
// offset that every read transaction subtracts (saturated) from the stored depth,
// in raster order, with tlast on the final pixel. Items are handled one at a time.
// An unmasked load passes through the bit-serial divider twice (plane term, then
// bin number, skipped when its numerator is negative); a masked load skips the
// divider. The last load of a frame adds a histogram scan; a load that finds its
// position outside a resized frame adds a clearing sweep. After reset the histogram
// is cleared before the first transaction is taken; configuration writes are taken
// at any time and must land while the block is idle. The depth store is
// MAX_WIDTH*MAX_HEIGHT words and is not cleared.
module phase_depth_mode_offset #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 512,
  parameter int BIN_COUNT  = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // phase_value[31:0], pixel_masked[32], zero pad
  input  logic        s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // depth_value[31:0]
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import pdmo_pkg::*;

  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(DEPTH);
  localparam int NPW    = $clog2(DEPTH + 1);
  localparam int BW     = $clog2(BIN_COUNT);
  localparam int BCW    = $clog2(BIN_COUNT + 1);
  localparam int HALF_W = BCW + 31;
  localparam int BNW    = HALF_W + 2;
  localparam int XW     = WW + 2;
  localparam int PAW    = (XW > RW + 1) ? XW : RW + 1;
  localparam int PPW    = DIV_NW + 2;

  // configuration registers
  logic [10:0]        width_px;
  logic [9:0]         height_px;
  logic               orientation;
  logic signed [31:0] depth_scale;
  logic signed [31:0] depth_skew;
  logic [30:0]        bin_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_px    <= 11'd640;
      height_px   <= 10'd480;
      orientation <= 1'b0;
      depth_scale <= 32'sd65536;
      depth_skew  <= 32'sd65536;
      bin_size    <= 31'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:    width_px    <= cfg_data[10:0];
        REG_HEIGHT:   height_px   <= cfg_data[9:0];
        REG_ORIENT:   orientation <= cfg_data[0];
        REG_SCALE:    depth_scale <= $signed(cfg_data);
        REG_SKEW:     depth_skew  <= $signed(cfg_data);
        REG_BIN_SIZE: bin_size    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // clamped frame size and bin width
  logic [WW-1:0]     frame_w;
  logic [HW-1:0]     frame_h;
  logic [30:0]       bin_w;
  logic [HALF_W-1:0] half_full;
  logic [HALF_W-1:0] half_r;
  logic [NPW-1:0]    n_r;

  always_comb begin
    if (width_px == '0) begin
      frame_w = WW'(1);
    end else if (32'(width_px) > MAX_WIDTH) begin
      frame_w = WW'(MAX_WIDTH);
    end else begin
      frame_w = WW'(width_px);
    end
    if (height_px == '0) begin
      frame_h = HW'(1);
    end else if (32'(height_px) > MAX_HEIGHT) begin
      frame_h = HW'(MAX_HEIGHT);
    end else begin
      frame_h = HW'(height_px);
    end
  end

  assign bin_w     = (bin_size == '0) ? 31'd1 : bin_size;
  assign half_full = HALF_W'(BIN_COUNT) * HALF_W'(bin_w);

  // derived sizes follow the registers in the next cycle
  always_ff @(posedge clk) begin
    half_r <= half_full >> 1;
    n_r    <= NPW'(frame_w) * NPW'(frame_h);
  end

  // sequencer state and position counters
  pdmo_state_t        state, state_next;
  logic [CW-1:0]      col;
  logic [RW-1:0]      row;
  logic [AW-1:0]      rp;
  logic signed [31:0] offset;

  logic               accept;
  logic               stale;
  logic               col_wrap;
  logic               row_wrap;

  // item payload and datapath registers
  logic signed [31:0] phase_r;
  logic               masked_r;
  logic               plane_neg;
  logic               diff_neg;
  logic [31:0]        diff_mag;
  logic [63:0]        prod_r;
  logic               prod_neg;
  logic signed [31:0] depth_r;
  logic [BW-1:0]      bin_r;
  logic               rd_last;

  // control outputs of the sequencer
  logic               div_start;
  hist_cmd_t          hist_cmd;
  hist_stat_t         hist_stat;
  logic               store_we;
  logic               store_re;
  logic               out_load;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign stale    = (32'(col) >= 32'(frame_w)) || (32'(row) >= 32'(frame_h));
  assign col_wrap = (32'(col) + 1) >= 32'(frame_w);
  assign row_wrap = (32'(row) + 1) >= 32'(frame_h);

  // plane numerator and denominator
  logic signed [XW-1:0]  xterm;
  logic signed [PAW-1:0] pa;
  logic signed [PPW-1:0] pprod;
  logic signed [PPW-1:0] pprod_abs;
  logic [DIV_NW-1:0]     pmag;
  logic [DIV_DW-1:0]     pden;

  assign xterm     = $signed(XW'({col, 1'b0})) - $signed(XW'(frame_w));
  assign pa        = orientation ? $signed(PAW'(row)) : PAW'(xterm);
  assign pprod     = PPW'(pa) * PPW'(depth_skew);
  assign pprod_abs = pprod[PPW-1] ? -pprod : pprod;
  assign pmag      = pprod_abs[DIV_NW-1:0];
  assign pden      = orientation ? DIV_DW'(frame_h) : DIV_DW'({frame_w, 1'b0});

  // bin numerator: depth shifted by half the histogram range
  logic signed [BNW-1:0] bnum;
  assign bnum = BNW'(depth_r) + $signed(BNW'(half_r));

  // shared divider
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic              div_busy;
  logic              div_done;
  logic [DIV_NW-1:0] div_quo;
  logic              div_rem_nz;

  assign div_num = (state == S_PLANE) ? pmag : DIV_NW'(unsigned'(bnum));
  assign div_den = (state == S_PLANE) ? pden : DIV_DW'(bin_w);

  pdmo_div #(
    .NW (DIV_NW),
    .DW (DIV_DW)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .busy   (div_busy),
    .done   (div_done),
    .quo    (div_quo),
    .rem_nz (div_rem_nz)
  );

  pdmo_hist #(
    .BIN_COUNT (BIN_COUNT)
  ) u_hist (
    .clk  (clk),
    .rst  (rst),
    .cmd  (hist_cmd),
    .stat (hist_stat)
  );

  // plane from floor division, then exact difference clamped to +-(2^32 - 1)
  logic signed [DIV_NW:0]   plane;
  logic signed [DIV_NW+1:0] diffw;
  logic signed [DIV_NW+1:0] diff_abs;

  assign plane    = plane_neg ? -$signed({1'b0, div_quo} + (DIV_NW + 1)'(div_rem_nz))
                              : $signed({1'b0, div_quo});
  assign diffw    = (DIV_NW + 2)'(phase_r) - (DIV_NW + 2)'(plane);
  assign diff_abs = diffw[DIV_NW+1] ? -diffw : diffw;

  // depth = floor(diff * scale / 2^16)
  logic [31:0]             scale_mag;
  logic signed [SAT_W-1:0] prod_s;
  logic signed [SAT_W-1:0] prod_sh;

  assign scale_mag = depth_scale[31] ? (~depth_scale + 32'd1) : depth_scale;
  assign prod_s    = prod_neg ? -$signed({1'b0, prod_r}) : $signed({1'b0, prod_r});
  assign prod_sh   = prod_s >>> 16;

  // offset from the winning bin
  logic signed [SAT_W-1:0] ofs_full;
  assign ofs_full = $signed(SAT_W'(hist_stat.best[BW-1:0])) * $signed(SAT_W'(bin_w))
                  - $signed(SAT_W'(half_r));

  // depth store address and read pointer update
  logic [NPW-1:0] posw;
  logic [AW-1:0]  rp_eff;
  logic [NPW-1:0] rp_inc;
  logic [AW-1:0]  rp_next;

  assign posw    = NPW'(row) * NPW'(frame_w) + NPW'(col);
  assign rp_eff  = (NPW'(rp) >= n_r) ? '0 : rp;
  assign rp_inc  = NPW'(rp_eff) + 1'b1;
  assign rp_next = (rp_inc >= n_r) ? '0 : AW'(rp_inc);

  // depth store
  logic signed [31:0] store [DEPTH];
  logic signed [31:0] store_rdata;

  always_ff @(posedge clk) begin
    if (store_we) store[AW'(posw)] <= depth_r;
    if (store_re) store_rdata <= store[rp_eff];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == OP_READ) begin
            state_next = S_RD_OUT;
          end else if (stale) begin
            state_next = S_CLR_WAIT;
          end else begin
            state_next = S_PLANE;
          end
        end
      end
      S_CLR_WAIT:   if (!hist_stat.busy) state_next = S_PLANE;
      S_PLANE:      state_next = masked_r ? S_STORE : S_PLANE_WAIT;
      S_PLANE_WAIT: if (div_done) state_next = S_MUL;
      S_MUL:        state_next = S_DEPTH;
      S_DEPTH:      state_next = S_BIN;
      S_BIN:        state_next = bnum[BNW-1] ? S_HIST : S_BIN_WAIT;
      S_BIN_WAIT:   if (div_done) state_next = S_HIST;
      S_HIST:       state_next = S_STORE;
      S_STORE:      state_next = (col_wrap && row_wrap) ? S_SCAN_REQ : S_IDLE;
      S_SCAN_REQ:   if (!hist_stat.busy) state_next = S_SCAN_WAIT;
      S_SCAN_WAIT:  if (!hist_stat.busy) state_next = S_IDLE;
      S_RD_OUT:     if (!m_axis_tvalid || m_axis_tready) state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    hist_cmd.op   = HOP_NONE;
    hist_cmd.bin  = BIN_IDX_W'(bin_r);
    store_we      = 1'b0;
    store_re      = 1'b0;
    out_load      = 1'b0;
    case (state)
      S_IDLE: begin
        s_axis_tready = !hist_stat.busy;
        if (accept && s_axis_tuser == OP_READ) store_re = 1'b1;
        if (accept && s_axis_tuser == OP_LOAD && stale) hist_cmd.op = HOP_CLEAR;
      end
      S_PLANE:    div_start = !masked_r;
      S_BIN:      div_start = !bnum[BNW-1];
      S_HIST:     hist_cmd.op = HOP_INC;
      S_STORE:    store_we = 1'b1;
      S_SCAN_REQ: if (!hist_stat.busy) hist_cmd.op = HOP_SCAN;
      S_RD_OUT:   out_load = !m_axis_tvalid || m_axis_tready;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      col           <= '0;
      row           <= '0;
      rp            <= '0;
      offset        <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      // restart a frame whose position no longer fits
      if (state == S_IDLE && accept && s_axis_tuser == OP_LOAD && stale) begin
        col <= '0;
        row <= '0;
      end
      if (state == S_IDLE && accept && s_axis_tuser == OP_READ) begin
        rp <= rp_next;
      end
      if (state == S_STORE) begin
        if (col_wrap) begin
          col <= '0;
          if (row_wrap) begin
            row <= '0;
            rp  <= '0;
          end else begin
            row <= row + 1'b1;
          end
        end else begin
          col <= col + 1'b1;
        end
      end
      if (state == S_SCAN_WAIT && !hist_stat.busy) begin
        offset <= sat32(ofs_full);
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept) begin
      phase_r  <= $signed(s_axis_tdata[31:0]);
      masked_r <= s_axis_tdata[32];
      rd_last  <= (rp_inc == n_r);
    end
    if (state == S_PLANE) begin
      plane_neg <= pprod[PPW-1];
      if (masked_r) depth_r <= '0;
    end
    if (state == S_PLANE_WAIT && div_done) begin
      diff_neg <= diffw[DIV_NW+1];
      diff_mag <= (diff_abs > (DIV_NW + 2)'(33'h0FFFFFFFF)) ? 32'hFFFFFFFF
                                                            : diff_abs[31:0];
    end
    if (state == S_MUL) begin
      prod_r   <= 64'(diff_mag) * 64'(scale_mag);
      prod_neg <= diff_neg ^ depth_scale[31];
    end
    if (state == S_DEPTH) begin
      depth_r <= sat32(prod_sh);
    end
    if (state == S_BIN && bnum[BNW-1]) begin
      bin_r <= '0;
    end
    if (state == S_BIN_WAIT && div_done) begin
      bin_r <= (div_quo > DIV_NW'(BIN_COUNT - 1)) ? BW'(BIN_COUNT - 1) : div_quo[BW-1:0];
    end
  end

  // output register
  logic signed [31:0] out_depth;
  logic               out_last;

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_depth <= sat32(SAT_W'(store_rdata) - SAT_W'(offset));
      out_last  <= rd_last;
    end
  end

  assign m_axis_tdata = out_depth;
  assign m_axis_tlast = out_last;

endmodule

// ===== sv/pdmo_checker.sv =====
// pdmo_checker: port-level assertions for phase_depth_mode_offset and its bind
// depends on pdmo_pkg
module pdmo_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  import pdmo_pkg::*;

  logic       in_acc;
  logic       rd_acc;
  logic       out_acc;
  logic [1:0] pend;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign rd_acc  = in_acc && s_axis_tuser == OP_READ;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // read transactions not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + 2'(rd_acc) - 2'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled result changed");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> pend != 2'd0)
    else $error("result without a read");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !s_axis_tready)
    else $error("input taken back to back");

  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    rd_acc |-> pend != 2'd2)
    else $error("read taken while two results pending");

endmodule

bind phase_depth_mode_offset pdmo_checker u_pdmo_checker (.*);

// ===== bench/phase_depth_mode_offset_test.sv =====
// phase_depth_mode_offset_test: self-checking bench for the phase to depth converter
// depends on pdmo_pkg and the phase_depth_mode_offset top level with its submodules
`timescale 1ns / 1ps

module phase_depth_mode_offset_test;
  import pdmo_pkg::*;

  localparam int  BINS       = 128;
  localparam int  SETTLE     = 600;       // worst load plus scan plus clearing sweep
  localparam int  CYCLE_CAP  = 4000000;
  localparam int  ITEM_GOAL  = 1350;
  localparam int  QUIET_FROM = 1150;

  typedef struct {
    logic              op;
    logic signed [31:0] phase;
    logic              masked;
  } pixel_txn_t;

  typedef struct {
    logic signed [31:0] depth;
    logic              last;
  } depth_txn_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // phase_value[31:0], pixel_masked[32], zero pad
  logic        s_axis_tuser = 1'b0; // opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // depth_value[31:0]
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  phase_depth_mode_offset u_dut (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_we, .cfg_index, .cfg_data
  );

  always #5 clk = ~clk;

  // pixel transactions waiting to go out, and depths the block owes us
  pixel_txn_t pixel_q[$];
  depth_txn_t depth_q[$];

  // shadow copy of the converter state
  longint     sh_width, sh_height, sh_orient, sh_scale, sh_skew, sh_bin;
  int unsigned sh_counts[BINS];
  int unsigned sh_col, sh_row, sh_rd;
  int         sh_offset;
  int         sh_store[int];

  int  n_loads, n_reads, n_frames, n_cfg, n_errors, n_checked, n_sent, n_generated;
  int  cycles;
  bit  sent_took;
  int  tx_gap, rx_gap, rx_hold;
  bit  quiet;

  function automatic longint fdiv(longint a, longint b);
    longint q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic int clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic longint frame_cols();
    return sh_width < 1 ? 1 : (sh_width > 1024 ? 1024 : sh_width);
  endfunction

  function automatic longint frame_rows();
    return sh_height < 1 ? 1 : (sh_height > 512 ? 512 : sh_height);
  endfunction

  function automatic longint bin_w();
    return sh_bin == 0 ? 1 : sh_bin;
  endfunction

  // depth of one loaded pixel plus the histogram and frame-end bookkeeping
  task automatic shadow_load(longint phase, bit masked);
    longint w, h, plane, diff, depth, half, num, bin;
    int unsigned best, best_cnt;
    w = frame_cols();
    h = frame_rows();
    half = fdiv(BINS * bin_w(), 2);
    depth = 0;
    if (sh_col >= w || sh_row >= h) begin
      // resized mid-frame: start over
      sh_col = 0;
      sh_row = 0;
      foreach (sh_counts[i]) sh_counts[i] = 0;
    end
    if (!masked) begin
      if (sh_orient == 0) plane = fdiv((2 * longint'(sh_col) - w) * sh_skew, 2 * w);
      else plane = fdiv(longint'(sh_row) * sh_skew, h);
      diff = phase - plane;
      if (diff > 64'sd4294967295) diff = 64'sd4294967295;
      if (diff < -64'sd4294967295) diff = -64'sd4294967295;
      depth = clamp32(fdiv(diff * sh_scale, 65536));
      num = depth + half;
      bin = num < 0 ? 0 : num / bin_w();
      if (bin > BINS - 1) bin = BINS - 1;
      if (sh_counts[bin] < 1048575) sh_counts[bin]++;
    end
    sh_store[int'(sh_row * w + sh_col)] = int'(depth);
    sh_col++;
    if (sh_col >= w) begin
      sh_col = 0;
      sh_row++;
      if (sh_row >= h) begin
        best = 0;
        best_cnt = 0;
        for (int i = 0; i < BINS; i++)
          if (sh_counts[i] > best_cnt) begin
            best_cnt = sh_counts[i];
            best = i;
          end
        sh_offset = clamp32(longint'(best) * bin_w() - half);
        foreach (sh_counts[i]) sh_counts[i] = 0;
        sh_row = 0;
        sh_rd = 0;
        n_frames++;
      end
    end
  endtask

  task automatic push_load(logic signed [31:0] phase, bit masked);
    pixel_txn_t t;
    t.op = OP_LOAD;
    t.phase = phase;
    t.masked = masked;
    pixel_q.push_back(t);
    shadow_load(longint'(phase), masked);
    n_loads++;
    n_generated++;
  endtask

  // reads only a position that a load has written
  task automatic push_read();
    pixel_txn_t t;
    depth_txn_t d;
    longint n;
    n = frame_cols() * frame_rows();
    if (sh_rd >= n) sh_rd = 0;
    if (!sh_store.exists(int'(sh_rd))) return;
    t.op = OP_READ;
    t.phase = $urandom;
    t.masked = $urandom_range(0, 1);
    pixel_q.push_back(t);
    d.depth = clamp32(longint'(sh_store[int'(sh_rd)]) - longint'(sh_offset));
    d.last = (sh_rd == n - 1);
    depth_q.push_back(d);
    sh_rd++;
    if (sh_rd >= n) sh_rd = 0;
    n_reads++;
    n_generated++;
  endtask

  function automatic logic signed [31:0] rand_phase();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WIDTH:    sh_width  = val & 32'h7ff;
      REG_HEIGHT:   sh_height = val & 32'h3ff;
      REG_ORIENT:   sh_orient = val & 32'h1;
      REG_SCALE:    sh_scale  = longint'($signed(val));
      REG_SKEW:     sh_skew   = longint'($signed(val));
      REG_BIN_SIZE: sh_bin    = val & 32'h7fffffff;
      default: ;
    endcase
    n_cfg++;
  endtask

  // everything sent, every depth back, then let trailing loads finish
  task automatic wait_idle();
    while (pixel_q.size() != 0 || s_axis_tvalid || depth_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_frame(bit mostly_masked);
    longint n;
    n = frame_cols() * frame_rows();
    for (longint i = 0; i < n; i++)
      push_load(rand_phase(), mostly_masked ? ($urandom_range(0, 15) != 0)
                                            : ($urandom_range(0, 3) == 0));
  endtask

  task automatic random_scale_skew();
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: v = $signed($urandom_range(0, 32'h0003_0000)) - 32'sh0001_8000;
    endcase
    cfg_write(REG_SCALE, v);
    v = $urandom_range(0, 1) ? $urandom : ($signed($urandom_range(0, 32'h0004_0000))
                                           - 32'sh0002_0000);
    cfg_write(REG_SKEW, v);
  endtask

  // sender: holds the offered transaction until it is taken
  always @(negedge clk) begin
    logic nv;
    nv = s_axis_tvalid;
    if (!rst && !(s_axis_tvalid && !sent_took)) begin
      if (s_axis_tvalid && sent_took) begin
        void'(pixel_q.pop_front());
        n_sent++;
      end
      if (tx_gap > 0) begin
        tx_gap--;
        nv = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        tx_gap = $urandom_range(0, 4);
        nv = 1'b0;
      end else if (pixel_q.size() != 0) begin
        nv = 1'b1;
        s_axis_tuser <= pixel_q[0].op;
        s_axis_tdata <= {7'b0, pixel_q[0].masked, pixel_q[0].phase};
      end else begin
        nv = 1'b0;
      end
    end
    s_axis_tvalid <= nv;
  end

  // receiver: random short stalls, plus a long hold when asked
  always @(negedge clk) begin
    logic nr;
    if (rst) begin
      nr = 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      nr = 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      nr = 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      rx_gap = $urandom_range(0, 4);
      nr = 1'b0;
    end else begin
      nr = 1'b1;
    end
    m_axis_tready <= nr;
  end

  // monitor: compare each output transaction against the oldest expected depth
  always @(posedge clk) begin
    depth_txn_t e;
    cycles++;
    sent_took = !rst && s_axis_tvalid && s_axis_tready;
    quiet = n_sent > QUIET_FROM;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (depth_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected depth %h", m_axis_tdata);
      end else begin
        e = depth_q.pop_front();
        n_checked++;
        if (m_axis_tdata !== e.depth || m_axis_tlast !== e.last) begin
          n_errors++;
          if (n_errors <= 10)
            $display("depth mismatch #%0d: expected %h last %b, got %h last %b",
                     n_checked, e.depth, e.last, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  initial begin
    int mode;
    sh_width = 640; sh_height = 480; sh_orient = 0;
    sh_scale = 65536; sh_skew = 65536; sh_bin = 65536;
    foreach (sh_counts[i]) sh_counts[i] = 0;
    sh_col = 0; sh_row = 0; sh_rd = 0; sh_offset = 0;
    n_loads = 0; n_reads = 0; n_frames = 0; n_cfg = 0; n_errors = 0;
    n_checked = 0; n_sent = 0; n_generated = 0; cycles = 0;
    sent_took = 0; tx_gap = 0; rx_gap = 0; rx_hold = 0; quiet = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (SETTLE) @(posedge clk);   // histogram clearing after reset

    // directed: tiny frame, every register, extreme phases, masked pixel, tlast wrap
    cfg_write(REG_WIDTH, 3);
    cfg_write(REG_HEIGHT, 2);
    cfg_write(REG_ORIENT, 0);
    cfg_write(REG_SCALE, 32'h0001_0000);
    cfg_write(REG_SKEW, 32'h0002_0000);
    cfg_write(REG_BIN_SIZE, 32'h0001_0000);
    push_load(32'sh7fffffff, 0);
    push_load(32'sh80000000, 0);
    push_load(0, 1);
    push_load(32'sh0001_0000, 0);
    push_load(32'sh0001_0000, 0);
    push_load(-32'sh0000_8000, 0);
    repeat (8) push_read();
    wait_idle();
    // receiver holds off while reads keep coming, so the input backs up
    rx_hold = 200;
    repeat (8) push_read();
    wait_idle();
    // horizontal plane, saturating scale, smallest bin, empty histogram
    cfg_write(REG_ORIENT, 1);
    cfg_write(REG_SCALE, 32'h7fffffff);
    cfg_write(REG_BIN_SIZE, 0);
    repeat (6) push_load($urandom, 1);
    repeat (3) push_read();
    wait_idle();
    cfg_write(REG_SCALE, 32'h8000_0000);
    cfg_write(REG_SKEW, 32'h8000_0000);
    cfg_write(REG_BIN_SIZE, 32'h7fffffff);
    push_load(32'sh7fffffff, 0);
    push_load(32'sh80000000, 0);
    repeat (4) push_load(rand_phase(), 0);
    repeat (6) push_read();
    wait_idle();

    // oversize sizes clamp to the store limits; the wide frame stays partial and
    // goes stale at the next resize, the tall one is mostly masked to keep it quick
    cfg_write(REG_WIDTH, 11'h7ff);
    cfg_write(REG_HEIGHT, 0);
    repeat (20) push_load(rand_phase(), $urandom_range(0, 3) == 0);
    repeat (4) push_read();
    wait_idle();
    cfg_write(REG_WIDTH, 0);
    cfg_write(REG_HEIGHT, 10'h3ff);
    load_frame(1);
    repeat (4) push_read();
    wait_idle();

    // random phases, each a fresh setting; the sender idles before every write
    while (n_generated < ITEM_GOAL) begin
      cfg_write(REG_WIDTH, $urandom_range(0, 7) == 0 ? $urandom_range(9, 40)
                                                     : $urandom_range(1, 8));
      cfg_write(REG_HEIGHT, $urandom_range(1, 4));
      cfg_write(REG_ORIENT, $urandom_range(0, 1));
      if ($urandom_range(0, 1)) random_scale_skew();
      if ($urandom_range(0, 2) == 0)
        cfg_write(REG_BIN_SIZE, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 32'h4_0000));
      mode = $urandom_range(0, 5);
      if (mode == 0) begin
        // one to five loads, then a resize that can leave the load position stale
        repeat ($urandom_range(1, 5)) push_load(rand_phase(), $urandom_range(0, 3) == 0);
        wait_idle();
        cfg_write(REG_WIDTH, $urandom_range(1, 3));
        cfg_write(REG_HEIGHT, 1);
        load_frame(0);
      end else if (mode == 1) begin
        // noise: loads and reads interleaved at random
        repeat ($urandom_range(5, 20))
          if ($urandom_range(0, 1)) push_load(rand_phase(), $urandom_range(0, 1));
          else push_read();
      end else begin
        repeat ($urandom_range(1, 2)) load_frame(0);
      end
      if (mode == 2) begin
        // long receiver hold while reads keep coming, so the input backs up
        wait_idle();
        rx_hold = 300;
      end
      repeat ($urandom_range(2, 30)) push_read();
      wait_idle();
    end

    wait_idle();
    $display("%0d loads, %0d reads, %0d frames, %0d register writes, %0d depths checked",
             n_loads, n_reads, n_frames, n_cfg, n_checked);
    if (n_errors == 0 && depth_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d depths never arrived", n_errors, depth_q.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
